FILE: hdl/srf_pkg.sv
package srf_pkg;

    localparam int WINDOW_MAX_DEF = 16;
    localparam int SAMPLE_W       = 16;
    localparam int LEN_REG_W      = 5;
    localparam int RANK_REG_W     = 4;
    localparam int CFG_DATA_W     = 5;
    localparam int CFG_INDEX_W    = 2;

    localparam logic [LEN_REG_W-1:0]  LEN_RESET  = 5'd16;
    localparam logic [RANK_REG_W-1:0] RANK_RESET = 4'd8;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_WINDOW_LENGTH = 2'd0,
        REG_OUTPUT_RANK   = 2'd1
    } srf_reg_t;

    typedef enum logic {
        ACT_SAMPLE = 1'b0,
        ACT_FLUSH  = 1'b1
    } srf_action_t;

    typedef struct packed {
        logic                       en;
        logic                       steady;
        logic signed [SAMPLE_W-1:0] sample;
    } srf_ctrl_t;

endpackage

FILE: hdl/srf_stream_if.sv
interface srf_in_if
    import srf_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic                       action;
    logic signed [SAMPLE_W-1:0] sample;

    modport source (output valid, output action, output sample, input ready);
    modport sink   (input valid, input action, input sample, output ready);
endinterface

interface srf_out_if
    import srf_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] filtered;

    modport source (output valid, output filtered, input ready);
    modport sink   (input valid, input filtered, output ready);
endinterface

FILE: hdl/srf_cell.sv
module srf_cell
    import srf_pkg::*;
#(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF,
    parameter int IDX        = 0
)
(
    input  logic                              clk,
    input  srf_ctrl_t                         ctrl,
    input  logic [$clog2(WINDOW_MAX+1)-1:0]   list_len,
    input  logic [$clog2(WINDOW_MAX+1)-1:0]   win_len,
    input  logic [$clog2(WINDOW_MAX)-1:0]     oldest_age,
    input  logic                              d_in,
    input  logic signed [SAMPLE_W-1:0]        lval_in,
    input  logic [$clog2(WINDOW_MAX)-1:0]     lage_in,
    input  logic                              lgt_in,
    input  logic signed [SAMPLE_W-1:0]        rval_in,
    input  logic [$clog2(WINDOW_MAX)-1:0]     rage_in,
    input  logic                              rgt_in,
    output logic signed [SAMPLE_W-1:0]        val,
    output logic [$clog2(WINDOW_MAX)-1:0]     age,
    output logic                              gt,
    output logic                              d_out,
    output logic signed [SAMPLE_W-1:0]        lval_out,
    output logic [$clog2(WINDOW_MAX)-1:0]     lage_out,
    output logic                              lgt_out,
    output logic signed [SAMPLE_W-1:0]        val_next
);

    localparam int LW = $clog2(WINDOW_MAX + 1);
    localparam int AW = $clog2(WINDOW_MAX);
    localparam logic [LW-1:0] IDX_L = LW'(IDX);

    logic signed [SAMPLE_W-1:0] val_reg;
    logic [AW-1:0]              age_reg;
    logic [AW-1:0]              age_next;
    logic                       del_here;

    assign val = val_reg;
    assign age = age_reg;
    assign gt  = val_reg > ctrl.sample;

    // the oldest entry leaves; cells above it close the gap
    assign del_here = ctrl.steady && (IDX_L < win_len) && (age_reg == oldest_age);
    assign d_out    = d_in | del_here;
    assign lval_out = d_out ? rval_in : val_reg;
    assign lage_out = d_out ? rage_in : age_reg;
    assign lgt_out  = (IDX_L < list_len) ? (d_out ? rgt_in : gt) : 1'b1;

    always_comb
    begin
        priority if (!lgt_out)
        begin
            val_next = lval_out;
            age_next = lage_out + AW'(1);
        end
        else if (lgt_in)
        begin
            val_next = lval_in;
            age_next = lage_in + AW'(1);
        end
        else
        begin
            val_next = ctrl.sample;
            age_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en)
        begin
            val_reg <= val_next;
            age_reg <= age_next;
        end
    end

endmodule

FILE: hdl/sliding_window_rank_filter_top.sv
// a result is registered and offered in the cycle after the request that completes it
// one request per cycle unless out_ch stalls, set by the compare-and-shift cell chain
// the first window_length-1 samples after reset, flush or a length write give no result
// reset: window empty, window_length 16, output_rank 8, no result pending
// cell contents are undefined until written and need no clearing pass
module sliding_window_rank_filter_top
    import srf_pkg::*;
#(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    srf_in_if.sink                 in_ch,
    srf_out_if.source              out_ch,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int LW = $clog2(WINDOW_MAX + 1);
    localparam int AW = $clog2(WINDOW_MAX);
    localparam int CW = (LW > LEN_REG_W) ? LW : LEN_REG_W;
    localparam logic [CW-1:0] WMAX_C = CW'(WINDOW_MAX);

    logic [LEN_REG_W-1:0]       win_len_reg;
    logic [RANK_REG_W-1:0]      rank_reg;
    logic [LW-1:0]              fill_reg;
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] filtered_reg;
    logic [LW-1:0]              fill_next;
    logic                       out_valid_next;

    logic [CW-1:0]              len_ext;
    logic [CW-1:0]              len_c;
    logic [LW-1:0]              len;
    logic [LW-1:0]              len_m1;
    logic [CW-1:0]              rank_ext;
    logic [AW-1:0]              rank_eff;
    logic                       steady;
    logic                       accept;
    logic                       take_sample;
    logic                       gives_result;
    logic [LW-1:0]              list_len;
    srf_ctrl_t                  ctrl;

    logic signed [SAMPLE_W-1:0] val_w      [WINDOW_MAX];
    logic [AW-1:0]              age_w      [WINDOW_MAX];
    logic                       gt_w       [WINDOW_MAX];
    logic                       d_w        [WINDOW_MAX];
    logic signed [SAMPLE_W-1:0] lval_w     [WINDOW_MAX];
    logic [AW-1:0]              lage_w     [WINDOW_MAX];
    logic                       lgt_w      [WINDOW_MAX];
    logic signed [SAMPLE_W-1:0] val_next_w [WINDOW_MAX];

    // effective window length
    assign len_ext = CW'(win_len_reg);
    always_comb
    begin
        priority if (len_ext == '0)
        begin
            len_c = CW'(1);
        end
        else if (len_ext > WMAX_C)
        begin
            len_c = WMAX_C;
        end
        else
        begin
            len_c = len_ext;
        end
    end
    assign len    = len_c[LW-1:0];
    assign len_m1 = len - LW'(1);

    assign rank_ext = CW'(rank_reg);
    assign rank_eff = (rank_ext > CW'(len_m1)) ? len_m1[AW-1:0] : rank_ext[AW-1:0];

    assign steady       = (fill_reg == len);
    assign in_ch.ready  = !out_valid_reg || out_ch.ready;
    assign accept       = in_ch.valid && in_ch.ready;
    assign take_sample  = accept && (in_ch.action == ACT_SAMPLE);
    assign gives_result = take_sample && (steady || (fill_reg + LW'(1) == len));
    assign list_len     = steady ? len_m1 : fill_reg;

    assign ctrl.en     = take_sample;
    assign ctrl.steady = steady;
    assign ctrl.sample = in_ch.sample;

    genvar i;
    generate
        for (i = 0; i < WINDOW_MAX; i++)
        begin : g_cell
            logic                       d_l;
            logic signed [SAMPLE_W-1:0] lval_l;
            logic [AW-1:0]              lage_l;
            logic                       lgt_l;
            logic signed [SAMPLE_W-1:0] val_r;
            logic [AW-1:0]              age_r;
            logic                       gt_r;

            if (i == 0)
            begin : g_left_end
                assign d_l    = 1'b0;
                assign lval_l = '0;
                assign lage_l = '0;
                assign lgt_l  = 1'b0;
            end
            else
            begin : g_left
                assign d_l    = d_w[i-1];
                assign lval_l = lval_w[i-1];
                assign lage_l = lage_w[i-1];
                assign lgt_l  = lgt_w[i-1];
            end

            if (i == WINDOW_MAX - 1)
            begin : g_right_end
                assign val_r = '0;
                assign age_r = '0;
                assign gt_r  = 1'b1;
            end
            else
            begin : g_right
                assign val_r = val_w[i+1];
                assign age_r = age_w[i+1];
                assign gt_r  = gt_w[i+1];
            end

            srf_cell #(
                .WINDOW_MAX (WINDOW_MAX),
                .IDX        (i)
            ) u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .list_len   (list_len),
                .win_len    (len),
                .oldest_age (len_m1[AW-1:0]),
                .d_in       (d_l),
                .lval_in    (lval_l),
                .lage_in    (lage_l),
                .lgt_in     (lgt_l),
                .rval_in    (val_r),
                .rage_in    (age_r),
                .rgt_in     (gt_r),
                .val        (val_w[i]),
                .age        (age_w[i]),
                .gt         (gt_w[i]),
                .d_out      (d_w[i]),
                .lval_out   (lval_w[i]),
                .lage_out   (lage_w[i]),
                .lgt_out    (lgt_w[i]),
                .val_next   (val_next_w[i])
            );
        end
    endgenerate

    always_comb
    begin
        fill_next = fill_reg;
        if (cfg_wr_en && (cfg_index == REG_WINDOW_LENGTH))
        begin
            fill_next = '0;
        end
        else if (accept && (in_ch.action == ACT_FLUSH))
        begin
            fill_next = '0;
        end
        else if (take_sample && !steady)
        begin
            fill_next = fill_reg + LW'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (gives_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_len_reg   <= LEN_RESET;
            rank_reg      <= RANK_RESET;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en && (cfg_index == REG_WINDOW_LENGTH))
            begin
                win_len_reg <= cfg_data[LEN_REG_W-1:0];
            end
            if (cfg_wr_en && (cfg_index == REG_OUTPUT_RANK))
            begin
                rank_reg <= cfg_data[RANK_REG_W-1:0];
            end
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (gives_result)
        begin
            filtered_reg <= val_next_w[rank_eff];
        end
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.filtered = filtered_reg;

endmodule
